// ===== design/separable_binomial_smoothing_3d_top_assert.svh =====
// ----------------------------------------------------------------------------
// separable binomial smoothing assertion macros
// implication checks clocked on i_clk, disabled while in reset
// ----------------------------------------------------------------------------
`ifndef SEPARABLE_BINOMIAL_SMOOTHING_3D_TOP_ASSERT_SVH
`define SEPARABLE_BINOMIAL_SMOOTHING_3D_TOP_ASSERT_SVH

// same-cycle implication
`define SBS3_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define SBS3_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/sbs3_pkg.sv =====
// ----------------------------------------------------------------------------
// sbs3_pkg
// sizes, sequencer states and binomial coefficients of the smoothing block
// ----------------------------------------------------------------------------
package sbs3_pkg;

    localparam int MAX_HEIGHT  = 32;
    localparam int MAX_WIDTH   = 32;
    localparam int MAX_DEPTH   = 4;
    localparam int MAX_RADIUS  = 6;
    localparam int DATA_W      = 52;
    localparam int STORE_DEPTH = MAX_HEIGHT * MAX_WIDTH * MAX_DEPTH;
    localparam int STORE_AW    = 12;
    localparam int LINE_DEPTH  = 32;
    localparam int LINE_AW     = 5;
    localparam int COEF_W      = 10;

    localparam logic [2:0] CFG_HEIGHT = 3'd0;
    localparam logic [2:0] CFG_WIDTH  = 3'd1;
    localparam logic [2:0] CFG_DEPTH  = 3'd2;
    localparam logic [2:0] CFG_RAD_Y  = 3'd3;
    localparam logic [2:0] CFG_RAD_X  = 3'd4;
    localparam logic [2:0] CFG_RAD_Z  = 3'd5;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_READ = 1'b1;

    localparam logic [1:0] AXIS_Y    = 2'd0;
    localparam logic [1:0] AXIS_X    = 2'd1;
    localparam logic [1:0] AXIS_Z    = 2'd2;
    localparam logic [1:0] AXIS_DONE = 2'd3;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RD_WAIT,
        ST_AXIS,
        ST_FILL,
        ST_FILL_END,
        ST_MAC,
        ST_D1,
        ST_D2,
        ST_WR,
        ST_SCALE,
        ST_SCALE_END
    } t_state;

    typedef logic [COEF_W-1:0] t_coef_row [0:12];

    localparam t_coef_row COEF_TAB [0:6] = '{
        '{10'd1, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0,
          10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0},
        '{10'd1, 10'd2, 10'd1, 10'd0, 10'd0, 10'd0, 10'd0,
          10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0},
        '{10'd1, 10'd4, 10'd6, 10'd4, 10'd1, 10'd0, 10'd0,
          10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0},
        '{10'd1, 10'd6, 10'd15, 10'd20, 10'd15, 10'd6, 10'd1,
          10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0},
        '{10'd1, 10'd8, 10'd28, 10'd56, 10'd70, 10'd56, 10'd28,
          10'd8, 10'd1, 10'd0, 10'd0, 10'd0, 10'd0},
        '{10'd1, 10'd10, 10'd45, 10'd120, 10'd210, 10'd252, 10'd210,
          10'd120, 10'd45, 10'd10, 10'd1, 10'd0, 10'd0},
        '{10'd1, 10'd12, 10'd66, 10'd220, 10'd495, 10'd792, 10'd924,
          10'd792, 10'd495, 10'd220, 10'd66, 10'd12, 10'd1}
    };

    function automatic logic [COEF_W-1:0] coef(input logic [2:0] r, input logic [3:0] j);
        logic [COEF_W-1:0] c;
        c = 10'd0;
        if (r <= 3'd6 && j <= 4'd12) begin
            c = COEF_TAB[r][j];
        end
        return c;
    endfunction

endpackage

// ===== design/sbs3_ram.sv =====
// ----------------------------------------------------------------------------
// sbs3_ram
// generic simple dual-port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
module sbs3_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [0:DEPTH-1];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/separable_binomial_smoothing_3d_top.sv =====
// ----------------------------------------------------------------------------
// separable_binomial_smoothing_3d_top
// 3-d separable binomial smoothing of a loaded volume with fixed-point output
// ----------------------------------------------------------------------------
// usage
//   the slave stream carries requests: tuser 0 loads the sample in tdata,
//   tuser 1 reads the next smoothed result. samples go in column-major order
//   (height fastest, then width, then depth). the load that completes the
//   volume starts the smoothing: y, x, then z passes, then a scaling pass.
//   the master stream returns one result per read request: tdata smoothed
//   value (8 fraction bits), tlast on the final result, tuser 1 if valid.
//   a read before the smoothing finishes returns zero with tuser 0.
// operation
//   a load writes the store directly; a read goes through the registered store read.
//   the smoothing runs with s_axis_tready low: for each axis with radius r
//   and line length n, each line is copied from the store into the line
//   buffer, then each of its n outputs sums 2r+1 taps through the single shared
//   multiply-accumulate unit; the scaling pass runs through the store read/write ports.
// reset and stall
//   reset clears counters and flags and restores the default configuration;
//   the store holds no valid data until loaded. while the master side stalls,
//   the result holds in the output register and no further request is taken.
// ----------------------------------------------------------------------------
`include "separable_binomial_smoothing_3d_top_assert.svh"

module separable_binomial_smoothing_3d_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // config write port
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_addr,
    input  logic [5:0]  i_cfg_data,
    // request stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [15:0] sample
    input  logic        s_axis_tuser,   // [0] cmd
    // result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // [23:0] smoothed
    output logic        m_axis_tlast,   // final_res
    output logic        m_axis_tuser    // [0] valid_res
);
    import sbs3_pkg::*;

    // configuration registers
    logic [5:0] r_h, r_w;
    logic [2:0] r_d, r_ry, r_rx, r_rz;

    // clamped geometry
    logic [5:0]  ch, cw;
    logic [2:0]  cd, cry, crx, crz;
    logic [11:0] area;
    logic [14:0] size_full;
    logic [12:0] size;
    logic [5:0]  shamt;

    // sequencer and datapath registers
    t_state r_state, n_state;
    logic [1:0]  r_axis, n_axis;
    logic [5:0]  r_o, n_o, r_q, n_q;
    logic [11:0] r_base_o, n_base_o, r_base, n_base, r_addr, n_addr;
    logic [5:0]  r_fi, n_fi, r_ci, n_ci;
    logic [3:0]  r_j, n_j;
    logic        r_fd_v, n_fd_v;
    logic [4:0]  r_fd_idx, n_fd_idx;
    logic        r_p1_act, n_p1_act, r_p1_v, n_p1_v;
    logic [3:0]  r_p1_j, n_p1_j;
    logic [DATA_W-1:0] r_prod, n_prod, r_acc, n_acc;
    logic        r_p2_act, n_p2_act;
    logic [11:0] r_sc, n_sc, r_sd_addr, n_sd_addr;
    logic        r_sd_v, n_sd_v;
    logic [12:0] r_lc, n_lc, r_rc, n_rc;
    logic        r_ready, n_ready;
    logic        r_rd_last, n_rd_last;
    logic        r_out_valid, n_out_valid;
    logic [23:0] r_out_data, n_out_data;
    logic        r_out_last, n_out_last, r_out_user, n_out_user;

    // per-axis line geometry
    logic [5:0]  p_n, p_o, p_q;
    logic [11:0] p_stride, p_bo, p_bq;
    logic [2:0]  p_r;

    // memory ports
    logic                st_we;
    logic [STORE_AW-1:0] st_waddr, st_raddr;
    logic [DATA_W-1:0]   st_wdata, st_rdata;
    logic                lb_we;
    logic [LINE_AW-1:0]  lb_waddr, lb_raddr;
    logic [DATA_W-1:0]   lb_rdata;

    logic        in_acc;
    logic        is_load, is_read;
    logic [12:0] lc_inc;
    logic        start_smooth;
    logic        read_last;
    logic [6:0]  tap_pos, tap_idx;
    logic        tap_in;
    logic [61:0] mul_full;
    logic [DATA_W-1:0] scaled;

    // clamping of sizes and radii
    always_comb begin
        ch  = (r_h == 6'd0) ? 6'd1 : ((r_h > 6'(MAX_HEIGHT)) ? 6'(MAX_HEIGHT) : r_h);
        cw  = (r_w == 6'd0) ? 6'd1 : ((r_w > 6'(MAX_WIDTH)) ? 6'(MAX_WIDTH) : r_w);
        cd  = (r_d == 3'd0) ? 3'd1 : ((r_d > 3'(MAX_DEPTH)) ? 3'(MAX_DEPTH) : r_d);
        cry = (r_ry > 3'(MAX_RADIUS)) ? 3'(MAX_RADIUS) : r_ry;
        crx = (r_rx > 3'(MAX_RADIUS)) ? 3'(MAX_RADIUS) : r_rx;
        crz = (r_rz > 3'(MAX_RADIUS)) ? 3'(MAX_RADIUS) : r_rz;
        area      = 12'({6'd0, ch} * {6'd0, cw});
        size_full = 15'({3'd0, area} * {12'd0, cd});
        size      = size_full[12:0];
        shamt     = 6'({3'd0, cry} + {3'd0, crx} + {3'd0, crz}) << 1;
    end

    // line geometry of the current axis
    always_comb begin
        unique case (r_axis)
            AXIS_Y: begin
                p_n = ch; p_stride = 12'd1; p_o = {3'd0, cd}; p_bo = area;
                p_q = cw; p_bq = {6'd0, ch}; p_r = cry;
            end
            AXIS_X: begin
                p_n = cw; p_stride = {6'd0, ch}; p_o = {3'd0, cd}; p_bo = area;
                p_q = ch; p_bq = 12'd1; p_r = crx;
            end
            AXIS_Z: begin
                p_n = {3'd0, cd}; p_stride = area; p_o = cw; p_bo = {6'd0, ch};
                p_q = ch; p_bq = 12'd1; p_r = crz;
            end
            default: begin
                p_n = 6'd1; p_stride = 12'd1; p_o = 6'd1; p_bo = 12'd0;
                p_q = 6'd1; p_bq = 12'd0; p_r = 3'd0;
            end
        endcase
    end

    assign s_axis_tready = (r_state == ST_IDLE) && (!r_out_valid || m_axis_tready);
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign is_load       = in_acc && (s_axis_tuser == CMD_LOAD) && !r_ready;
    assign is_read       = in_acc && (s_axis_tuser == CMD_READ);
    assign lc_inc        = (r_lc < size) ? r_lc + 13'd1 : r_lc;
    assign start_smooth  = lc_inc >= size;
    assign read_last     = ({1'b0, r_rc} + 14'd1) >= {1'b0, size};

    // tap position inside the zero-padded line
    assign tap_pos  = 7'({1'b0, r_ci} + {3'd0, r_j});
    assign tap_idx  = tap_pos - {4'd0, p_r};
    assign tap_in   = (tap_pos >= {4'd0, p_r}) && (tap_idx < {1'b0, p_n});
    assign mul_full = 62'(lb_rdata * coef(p_r, r_p1_j));

    // fixed-point scaling, 8 fraction bits kept
    always_comb begin
        if (shamt >= 6'd8) begin
            scaled = st_rdata >> (shamt - 6'd8);
        end else begin
            scaled = st_rdata << (6'd8 - shamt);
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (is_load && start_smooth) begin
                    n_state = ST_AXIS;
                end else if (is_read && r_ready) begin
                    n_state = ST_RD_WAIT;
                end
            end
            ST_RD_WAIT: n_state = ST_IDLE;
            ST_AXIS: begin
                if (r_axis == AXIS_DONE) begin
                    n_state = ST_SCALE;
                end else if (p_r != 3'd0) begin
                    n_state = ST_FILL;
                end
            end
            ST_FILL: begin
                if (r_fi == p_n - 6'd1) begin
                    n_state = ST_FILL_END;
                end
            end
            ST_FILL_END: n_state = ST_MAC;
            ST_MAC: begin
                if (r_j == {p_r, 1'b0}) begin
                    n_state = ST_D1;
                end
            end
            ST_D1: n_state = ST_D2;
            ST_D2: n_state = ST_WR;
            ST_WR: begin
                if (r_ci == p_n - 6'd1) begin
                    if (r_q == p_q - 6'd1 && r_o == p_o - 6'd1) begin
                        n_state = ST_AXIS;
                    end else begin
                        n_state = ST_FILL;
                    end
                end else begin
                    n_state = ST_MAC;
                end
            end
            ST_SCALE: begin
                if ({1'b0, r_sc} == size - 13'd1) begin
                    n_state = ST_SCALE_END;
                end
            end
            ST_SCALE_END: n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    // datapath and memory control
    always_comb begin
        n_axis = r_axis; n_o = r_o; n_q = r_q; n_base_o = r_base_o; n_base = r_base;
        n_addr = r_addr; n_fi = r_fi; n_ci = r_ci; n_j = r_j; n_acc = r_acc;
        n_sc = r_sc; n_lc = r_lc; n_rc = r_rc; n_ready = r_ready; n_rd_last = r_rd_last;
        n_out_data = r_out_data; n_out_last = r_out_last; n_out_user = r_out_user;
        n_out_valid = r_out_valid && !m_axis_tready;
        n_fd_v = 1'b0; n_fd_idx = r_fi[LINE_AW-1:0];
        n_sd_v = 1'b0; n_sd_addr = r_sc;
        n_p1_act = 1'b0; n_p1_v = tap_in; n_p1_j = r_j;
        n_p2_act = r_p1_act;
        n_prod   = r_p1_v ? mul_full[DATA_W-1:0] : '0;
        st_we = 1'b0; st_waddr = r_lc[STORE_AW-1:0];
        st_wdata = {{(DATA_W-16){1'b0}}, s_axis_tdata};
        st_raddr = r_rc[STORE_AW-1:0];
        lb_we = r_fd_v; lb_waddr = r_fd_idx; lb_raddr = tap_idx[LINE_AW-1:0];

        if (r_p2_act) begin
            n_acc = r_acc + r_prod;
        end

        // scaling pass write-back, in the cycle after its read
        if (r_sd_v) begin
            st_we    = 1'b1;
            st_waddr = r_sd_addr;
            st_wdata = {{(DATA_W-24){1'b0}}, scaled[23:0]};
        end

        unique case (r_state)
            ST_IDLE: begin
                if (is_load) begin
                    st_we = (r_lc < size);
                    n_lc  = lc_inc;
                    n_axis = AXIS_Y;
                end
                if (is_read) begin
                    if (r_ready) begin
                        n_rd_last = read_last;
                        if (read_last) begin
                            n_lc = '0; n_rc = '0; n_ready = 1'b0;
                        end else begin
                            n_rc = r_rc + 13'd1;
                        end
                    end else begin
                        // early read returns an invalid zero result
                        n_out_valid = 1'b1;
                        n_out_data  = '0;
                        n_out_last  = 1'b0;
                        n_out_user  = 1'b0;
                    end
                end
            end
            ST_RD_WAIT: begin
                n_out_valid = 1'b1;
                n_out_data  = st_rdata[23:0];
                n_out_last  = r_rd_last;
                n_out_user  = 1'b1;
            end
            ST_AXIS: begin
                if (r_axis == AXIS_DONE) begin
                    n_sc = '0;
                end else if (p_r == 3'd0) begin
                    n_axis = r_axis + 2'd1;
                end else begin
                    n_o = '0; n_q = '0; n_base_o = '0; n_base = '0;
                    n_addr = '0; n_fi = '0;
                end
            end
            ST_FILL: begin
                st_raddr = r_addr;
                n_fd_v   = 1'b1;
                n_addr   = r_addr + p_stride;
                n_fi     = r_fi + 6'd1;
            end
            ST_FILL_END: begin
                n_addr = r_base; n_ci = '0; n_j = '0; n_acc = '0;
            end
            ST_MAC: begin
                n_p1_act = 1'b1;
                n_j      = r_j + 4'd1;
            end
            ST_D1, ST_D2: begin
            end
            ST_WR: begin
                st_we    = 1'b1;
                st_waddr = r_addr;
                st_wdata = r_acc;
                n_addr   = r_addr + p_stride;
                n_ci     = r_ci + 6'd1;
                n_j      = '0;
                n_acc    = '0;
                if (r_ci == p_n - 6'd1) begin
                    n_fi = '0;
                    if (r_q == p_q - 6'd1) begin
                        n_q      = '0;
                        n_o      = r_o + 6'd1;
                        n_base_o = r_base_o + p_bo;
                        n_base   = r_base_o + p_bo;
                        n_addr   = r_base_o + p_bo;
                        if (r_o == p_o - 6'd1) begin
                            n_axis = r_axis + 2'd1;
                        end
                    end else begin
                        n_q    = r_q + 6'd1;
                        n_base = r_base + p_bq;
                        n_addr = r_base + p_bq;
                    end
                end
            end
            ST_SCALE: begin
                st_raddr = r_sc;
                n_sd_v   = 1'b1;
                n_sc     = r_sc + 12'd1;
            end
            ST_SCALE_END: begin
                n_ready = 1'b1;
            end
            default: begin
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_h <= 6'd32; r_w <= 6'd32; r_d <= 3'd1;
            r_ry <= 3'd1; r_rx <= 3'd1; r_rz <= 3'd0;
            r_state <= ST_IDLE;
            r_lc <= '0; r_rc <= '0; r_ready <= 1'b0;
            r_out_valid <= 1'b0;
            r_fd_v <= 1'b0; r_sd_v <= 1'b0; r_p1_act <= 1'b0; r_p2_act <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    CFG_HEIGHT: r_h  <= i_cfg_data;
                    CFG_WIDTH:  r_w  <= i_cfg_data;
                    CFG_DEPTH:  r_d  <= i_cfg_data[2:0];
                    CFG_RAD_Y:  r_ry <= i_cfg_data[2:0];
                    CFG_RAD_X:  r_rx <= i_cfg_data[2:0];
                    CFG_RAD_Z:  r_rz <= i_cfg_data[2:0];
                    default: begin
                    end
                endcase
            end
            r_state <= n_state;
            r_lc <= n_lc; r_rc <= n_rc; r_ready <= n_ready;
            r_out_valid <= n_out_valid;
            r_fd_v <= n_fd_v; r_sd_v <= n_sd_v; r_p1_act <= n_p1_act; r_p2_act <= n_p2_act;
        end
    end

    // payload and loop registers
    always_ff @(posedge i_clk) begin
        r_axis <= n_axis; r_o <= n_o; r_q <= n_q; r_base_o <= n_base_o; r_base <= n_base;
        r_addr <= n_addr; r_fi <= n_fi; r_ci <= n_ci; r_j <= n_j; r_acc <= n_acc;
        r_fd_idx <= n_fd_idx; r_p1_v <= n_p1_v; r_p1_j <= n_p1_j; r_prod <= n_prod;
        r_sc <= n_sc; r_sd_addr <= n_sd_addr; r_rd_last <= n_rd_last;
        r_out_data <= n_out_data; r_out_last <= n_out_last; r_out_user <= n_out_user;
    end

    // sample and sum store
    sbs3_ram #(.WIDTH(DATA_W), .DEPTH(STORE_DEPTH)) u_store (
        .i_clk   (i_clk),
        .i_we    (st_we),
        .i_waddr (st_waddr),
        .i_wdata (st_wdata),
        .i_raddr (st_raddr),
        .o_rdata (st_rdata)
    );

    // one line under smoothing
    sbs3_ram #(.WIDTH(DATA_W), .DEPTH(LINE_DEPTH)) u_line (
        .i_clk   (i_clk),
        .i_we    (lb_we),
        .i_waddr (lb_waddr),
        .i_wdata (st_rdata),
        .i_raddr (lb_raddr),
        .o_rdata (lb_rdata)
    );

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tlast  = r_out_last;
    assign m_axis_tuser  = r_out_user;

    `SBS3_ASSERT_IMP(a_busy_not_ready,
        (r_state != ST_IDLE && r_state != ST_RD_WAIT), !r_ready,
        "results flagged ready during smoothing")
    `SBS3_ASSERT_NXT(a_read_fetch, (is_read && r_ready), (r_state == ST_RD_WAIT),
        "ready read did not fetch from store")
    `SBS3_ASSERT_IMP(a_last_is_valid, (m_axis_tvalid && m_axis_tlast), m_axis_tuser,
        "final result marked invalid")

endmodule
